>>> hdl/kvi_pkg.sv
`timescale 1ns / 1ps
package kvi_pkg;
    localparam int KEYS   = 16;
    localparam int SLOT_W = $clog2(KEYS);
    localparam int CNT_W  = 5;
    localparam int TIME_W = 24;
    localparam int VAL_W  = 32;
    localparam int FRAC_W = 16;
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [3:0]               key_slot;
        logic [TIME_W-1:0]        key_time;
        logic signed [VAL_W-1:0]  val_x;
        logic signed [VAL_W-1:0]  val_y;
        logic signed [VAL_W-1:0]  val_z;
        logic [TIME_W-1:0]        query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]  out_x;
        logic signed [VAL_W-1:0]  out_y;
        logic signed [VAL_W-1:0]  out_z;
        logic [3:0]               segment;
        logic                     clamped;
    } t_out_item;

    // Queue entry between front and back: the decoded query.
    typedef struct packed {
        logic [TIME_W-1:0]  query_time;
        logic [SLOT_W:0]    n;
    } t_job;
endpackage

>>> hdl/kvi_if.sv
`timescale 1ns / 1ps
interface kvi_in_if;
    logic               valid;
    logic               ready;
    kvi_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kvi_out_if;
    logic                valid;
    logic                ready;
    kvi_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kvi_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [kvi_pkg::CNT_W-1:0]     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/keyframe_vector_interpolator.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                          Accept
// s_in     in   kind, key_slot, key_time, val_x/y/z, query_time  valid & ready
// m_out    out  out_x/y/z, segment, clamped                      valid & ready
// s_cfg    in   key_count (5 bits)                               valid & ready
//
// A load waits until no query is queued or in the back end, so it never
// changes a key under an earlier query.
// From the pop, a query ends on a key (one-key track, before the first key, on
// or past the last) or interpolates: the search reads the keys one by one, the
// factor comes from a 16-step restoring divider, then one shared multiplier
// works through the components in turn.
// Reset (i_rst_n, synchronous) sets key_count to 1 and empties the queue;
// key slots hold nothing defined until loaded.
// Queries pass through a two-entry queue, so the front keeps taking queries
// while the back works or the output register waits on m_out.ready.
module keyframe_vector_interpolator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvi_in_if.sink     s_in,
    kvi_cfg_if.sink    s_cfg,
    kvi_out_if.source  m_out
);
    logic                        w_push, w_full, w_pop, w_qv, w_wr;
    logic                        w_back_busy, w_busy;
    kvi_pkg::t_job               w_job_in, w_job_out;
    logic [kvi_pkg::SLOT_W-1:0]  w_slot;
    logic [kvi_pkg::TIME_W-1:0]  w_time;
    logic [3*kvi_pkg::VAL_W-1:0] w_vec;

    // a query is in flight while queued or while the back works on it
    assign w_busy = w_qv || w_back_busy;

    kvi_front u_front (
        .i_clk, .i_rst_n, .s_in, .s_cfg,
        .i_q_full(w_full), .i_busy(w_busy), .o_push(w_push), .o_job(w_job_in),
        .o_wr(w_wr), .o_wr_slot(w_slot), .o_wr_time(w_time), .o_wr_vec(w_vec)
    );

    kvi_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_job_in), .o_full(w_full),
        .i_pop(w_pop), .o_valid(w_qv), .o_job(w_job_out)
    );

    kvi_back u_back (
        .i_clk, .i_rst_n, .i_wr(w_wr), .i_wr_slot(w_slot), .i_wr_time(w_time),
        .i_wr_vec(w_vec), .i_q_valid(w_qv), .i_job(w_job_out), .o_pop(w_pop),
        .o_busy(w_back_busy), .m_out
    );
endmodule

>>> hdl/kvi_queue.sv
`timescale 1ns / 1ps
module kvi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kvi_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output kvi_pkg::t_job o_job
);
    // Two-entry FIFO.
    kvi_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule

>>> hdl/kvi_front.sv
`timescale 1ns / 1ps
module kvi_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    kvi_in_if.sink                      s_in,
    kvi_cfg_if.sink                     s_cfg,
    input  logic                        i_q_full,
    input  logic                        i_busy,
    output logic                        o_push,
    output kvi_pkg::t_job               o_job,
    output logic                        o_wr,
    output logic [kvi_pkg::SLOT_W-1:0]  o_wr_slot,
    output logic [kvi_pkg::TIME_W-1:0]  o_wr_time,
    output logic [3*kvi_pkg::VAL_W-1:0] o_wr_vec
);
    logic [kvi_pkg::CNT_W-1:0] r_count;
    logic [kvi_pkg::SLOT_W:0]  w_n;
    logic                      w_acc;

    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= kvi_pkg::CNT_W'(1);
        else if (s_cfg.valid) r_count <= s_cfg.data;
    end

    // Clamp the count to 1..KEYS.
    always_comb begin
        if (r_count == '0) w_n = (kvi_pkg::SLOT_W+1)'(1);
        else if (32'(r_count) > kvi_pkg::KEYS) w_n = (kvi_pkg::SLOT_W+1)'(kvi_pkg::KEYS);
        else w_n = (kvi_pkg::SLOT_W+1)'(r_count);
    end

    // Loads wait until no query is queued or being worked; queries wait for queue room.
    assign s_in.ready = (s_in.data.kind == kvi_pkg::KIND_LOAD) ? !i_busy : !i_q_full;
    assign w_acc      = s_in.valid && s_in.ready;
    assign o_push     = w_acc && (s_in.data.kind == kvi_pkg::KIND_QUERY);
    assign o_job.query_time = s_in.data.query_time;
    assign o_job.n          = w_n;
    assign o_wr       = w_acc && (s_in.data.kind == kvi_pkg::KIND_LOAD)
                        && (32'(s_in.data.key_slot) < kvi_pkg::KEYS);
    assign o_wr_slot  = kvi_pkg::SLOT_W'(s_in.data.key_slot);
    assign o_wr_time  = s_in.data.key_time;
    assign o_wr_vec   = {s_in.data.val_x, s_in.data.val_y, s_in.data.val_z};

    a_push_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !o_wr) else $error("load and query at once");
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_n != '0) && (32'(w_n) <= kvi_pkg::KEYS)) else $error("count clamp");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in.valid && i_q_full && s_in.data.kind == kvi_pkg::KIND_QUERY)
        |-> !o_push) else $error("push into full queue");
endmodule

>>> hdl/kvi_back.sv
`timescale 1ns / 1ps
module kvi_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [kvi_pkg::SLOT_W-1:0]  i_wr_slot,
    input  logic [kvi_pkg::TIME_W-1:0]  i_wr_time,
    input  logic [3*kvi_pkg::VAL_W-1:0] i_wr_vec,
    input  logic                        i_q_valid,
    input  kvi_pkg::t_job               i_job,
    output logic                        o_pop,
    output logic                        o_busy,
    kvi_out_if.source                   m_out
);
    localparam int SW = kvi_pkg::SLOT_W;
    localparam int TW = kvi_pkg::TIME_W;
    localparam int VW = kvi_pkg::VAL_W;
    localparam int FW = kvi_pkg::FRAC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_CHK0, S_SRCH, S_SRCHW, S_RDE, S_DIV, S_MUL,
        S_SUM, S_KEY, S_OUT
    } t_state;

    // Key stores: one write, one registered read port each.
    logic [TW-1:0]   r_times [kvi_pkg::KEYS];
    logic [3*VW-1:0] r_vecs  [kvi_pkg::KEYS];
    logic [SW-1:0]   w_ra;
    logic [TW-1:0]   r_rt;
    logic [3*VW-1:0] r_rv;

    t_state          r_st;
    logic [TW-1:0]   r_q;
    logic [SW:0]     r_n;
    logic [SW:0]     r_i;        // probed key index
    logic [TW-1:0]   r_ti;       // start key time
    logic [3*VW-1:0] r_sv;       // start vector
    logic [TW-1:0]   r_span;
    logic [TW:0]     r_rem;
    logic [FW-1:0]   r_f;
    logic [4:0]      r_bit;
    logic [1:0]      r_c;        // component under multiply
    logic signed [VW:0]    r_d;
    logic signed [VW+FW+1:0] r_p;
    logic [3*VW-1:0] r_res;
    logic [SW-1:0]   r_seg;
    logic            r_clamp;
    logic            r_ovalid;
    kvi_pkg::t_out_item r_odata;

    logic [TW:0]     w_rem2;
    logic signed [VW:0] w_s, w_e;
    logic signed [VW+FW+1:0] w_sum;
    logic signed [VW+FW+1:0] w_prod;

    always_comb begin
        unique case (r_st)
            S_SRCH, S_SRCHW: w_ra = r_i[SW-1:0];
            default:         w_ra = r_i[SW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_times[i_wr_slot] <= i_wr_time;
            r_vecs[i_wr_slot]  <= i_wr_vec;
        end
        r_rt <= r_times[w_ra];
        r_rv <= r_vecs[w_ra];
    end

    assign w_rem2 = {r_rem[TW-1:0], 1'b0};
    always_comb begin
        unique case (r_c)
            2'd0:    begin w_s = {r_sv[3*VW-1], r_sv[3*VW-1:2*VW]};
                           w_e = {r_rv[3*VW-1], r_rv[3*VW-1:2*VW]}; end
            2'd1:    begin w_s = {r_sv[2*VW-1], r_sv[2*VW-1:VW]};
                           w_e = {r_rv[2*VW-1], r_rv[2*VW-1:VW]}; end
            default: begin w_s = {r_sv[VW-1], r_sv[VW-1:0]};
                           w_e = {r_rv[VW-1], r_rv[VW-1:0]}; end
        endcase
    end
    // difference times factor, both operands widened to the product width
    assign w_prod = r_d * $signed({1'b0, r_f});
    // start + (product >>> 16), floor by arithmetic shift
    assign w_sum = (VW+FW+2)'(w_s) + (r_p >>> FW);

    assign o_pop  = (r_st == S_IDLE) && i_q_valid && !r_ovalid;
    assign o_busy = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_out.ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (o_pop) begin
                    r_q  <= i_job.query_time;
                    r_n  <= i_job.n;
                    r_i  <= '0;
                    r_st <= S_RD0;
                end
                S_RD0: r_st <= S_CHK0;   // key 0 read in flight
                S_CHK0: begin
                    r_ti <= r_rt;
                    r_sv <= r_rv;
                    r_seg <= '0;
                    if (r_n == (SW+1)'(1)) begin
                        r_clamp <= 1'b0;
                        r_res   <= r_rv;
                        r_st    <= S_OUT;
                    end else if (r_q < r_rt) begin
                        r_clamp <= 1'b1;
                        r_res   <= r_rv;
                        r_st    <= S_OUT;
                    end else begin
                        r_i  <= (SW+1)'(1);
                        r_st <= S_SRCH;
                    end
                end
                S_SRCH: r_st <= S_SRCHW;   // read key r_i
                S_SRCHW: begin
                    if (r_q < r_rt) begin
                        r_seg  <= SW'(r_i - (SW+1)'(1));
                        r_span <= r_rt - r_ti;
                        r_rem  <= {1'b0, r_q - r_ti};
                        r_bit  <= 5'(FW);
                        r_st   <= S_DIV;
                    end else if (r_i == r_n - (SW+1)'(1)) begin
                        r_seg   <= SW'(r_i);
                        r_clamp <= (r_q > r_rt);
                        r_res   <= r_rv;
                        r_st    <= S_OUT;
                    end else begin
                        r_ti <= r_rt;
                        r_sv <= r_rv;
                        r_i  <= r_i + (SW+1)'(1);
                        r_st <= S_SRCH;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (w_rem2 >= {1'b0, r_span}) begin
                        r_rem <= w_rem2 - {1'b0, r_span};
                        r_f   <= {r_f[FW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_f   <= {r_f[FW-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd1) begin
                        r_c  <= 2'd0;
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_d  <= w_e - w_s;
                    r_st <= S_KEY;
                end
                S_KEY: begin
                    r_p  <= w_prod;
                    r_st <= S_SUM;
                end
                S_SUM: begin
                    r_res <= {r_res[2*VW-1:0], w_sum[VW-1:0]};
                    if (r_c == 2'd2) begin
                        r_clamp <= 1'b0;
                        r_st    <= S_OUT;
                    end else begin
                        r_c  <= r_c + 2'd1;
                        r_st <= S_MUL;
                    end
                end
                S_OUT: if (!r_ovalid || m_out.ready) begin
                    r_odata.out_x   <= r_res[3*VW-1:2*VW];
                    r_odata.out_y   <= r_res[2*VW-1:VW];
                    r_odata.out_z   <= r_res[VW-1:0];
                    r_odata.segment <= 4'(r_seg);
                    r_odata.clamped <= r_clamp;
                    r_ovalid        <= 1'b1;
                    r_st            <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_odata;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && r_ovalid && !m_out.ready) |=> r_st == S_OUT)
        else $error("result overwritten");
    a_div_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DIV) |-> r_span != '0) else $error("zero span");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SRCHW) |-> r_i < r_n) else $error("search past count");
endmodule
